// File: hw/rtl/mahd_pkg.sv
// ----------------------------------------------------------------------------
// mahd_pkg
// Types, codes and lookup tables shared by the audio frame header decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mahd_pkg;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_SYNC    = 3'd1,
    ERR_VERSION = 3'd2,
    ERR_LAYER   = 3'd3,
    ERR_BITRATE = 3'd4,
    ERR_RATE    = 3'd5
  } err_t;

  // version field codes in the header and decoded version numbers
  localparam logic [1:0] VCODE_MPEG25   = 2'd0;
  localparam logic [1:0] VCODE_RESERVED = 2'd1;
  localparam logic [1:0] VCODE_MPEG2    = 2'd2;
  localparam logic [1:0] VCODE_MPEG1    = 2'd3;
  localparam logic [1:0] VER_MPEG1      = 2'd0;
  localparam logic [1:0] VER_MPEG2      = 2'd1;
  localparam logic [1:0] VER_MPEG25     = 2'd2;

  // layer field codes
  localparam logic [1:0] LCODE_RESERVED = 2'd0;
  localparam logic [1:0] LCODE_LAYER3   = 2'd1;
  localparam logic [1:0] LCODE_LAYER2   = 2'd2;
  localparam logic [1:0] LCODE_LAYER1   = 2'd3;

  // sample-rate index codes
  localparam logic [1:0] RIDX_44K1     = 2'd0;
  localparam logic [1:0] RIDX_48K      = 2'd1;
  localparam logic [1:0] RIDX_32K      = 2'd2;
  localparam logic [1:0] RIDX_RESERVED = 2'd3;

  localparam logic [3:0] BIDX_FREE = 4'd0;

  // floor(x / 147) == (x * RECIP_147) >> RECIP_SHIFT for x < 2**19
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [19:0] RECIP_147   = 20'd913046;

  localparam logic [8:0] KBPS_TABLE [6][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  typedef struct packed {
    logic        ok;
    err_t        err;
    logic [1:0]  ver;
    logic [1:0]  layer;
    logic [1:0]  ridx;
    logic [15:0] rate;
    logic [8:0]  kbps;
    logic        pad;
    logic [11:0] prod;
    logic [17:0] ftime;
  } dec_t;

  typedef struct packed {
    dec_t        dec;
    logic [11:0] q44;
  } mul_t;

  typedef struct packed {
    logic        ok;
    err_t        err;
    logic [1:0]  ver;
    logic [1:0]  layer;
    logic [15:0] rate;
    logic [8:0]  kbps;
    logic        pad;
    logic [11:0] fbytes;
    logic [17:0] ftime;
  } res_t;

  function automatic logic [15:0] rate_hz(logic [1:0] ver, logic [1:0] ridx);
    logic [15:0] base;
    case (ridx)
      RIDX_44K1: base = 16'd44100;
      RIDX_48K:  base = 16'd48000;
      RIDX_32K:  base = 16'd32000;
      default:   base = 16'd0;
    endcase
    return base >> ver;
  endfunction

  function automatic logic [17:0] frame_time(logic [1:0] layer, logic [1:0] ver,
                                             logic [1:0] ridx);
    logic [17:0] t;
    t = 18'd0;
    if (layer == 2'd1) begin
      case ({ver, ridx})
        {VER_MPEG1, RIDX_44K1}:  t = 18'd8707;
        {VER_MPEG1, RIDX_48K}:   t = 18'd8000;
        {VER_MPEG1, RIDX_32K}:   t = 18'd12000;
        {VER_MPEG2, RIDX_44K1}:  t = 18'd17414;
        {VER_MPEG2, RIDX_48K}:   t = 18'd16000;
        {VER_MPEG2, RIDX_32K}:   t = 18'd24000;
        {VER_MPEG25, RIDX_44K1}: t = 18'd34829;
        {VER_MPEG25, RIDX_48K}:  t = 18'd32000;
        {VER_MPEG25, RIDX_32K}:  t = 18'd48000;
        default:                 t = 18'd0;
      endcase
    end else if (layer == 2'd2 || ver == VER_MPEG1) begin
      case ({ver, ridx})
        {VER_MPEG1, RIDX_44K1}:  t = 18'd26122;
        {VER_MPEG1, RIDX_48K}:   t = 18'd24000;
        {VER_MPEG1, RIDX_32K}:   t = 18'd36000;
        {VER_MPEG2, RIDX_44K1}:  t = 18'd52244;
        {VER_MPEG2, RIDX_48K}:   t = 18'd48000;
        {VER_MPEG2, RIDX_32K}:   t = 18'd72000;
        {VER_MPEG25, RIDX_44K1}: t = 18'd104489;
        {VER_MPEG25, RIDX_48K}:  t = 18'd96000;
        {VER_MPEG25, RIDX_32K}:  t = 18'd144000;
        default:                 t = 18'd0;
      endcase
    end else begin
      case ({ver, ridx})
        {VER_MPEG2, RIDX_44K1}:  t = 18'd26122;
        {VER_MPEG2, RIDX_48K}:   t = 18'd24000;
        {VER_MPEG2, RIDX_32K}:   t = 18'd36000;
        {VER_MPEG25, RIDX_44K1}: t = 18'd52244;
        {VER_MPEG25, RIDX_48K}:  t = 18'd48000;
        {VER_MPEG25, RIDX_32K}:  t = 18'd72000;
        default:                 t = 18'd0;
      endcase
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mahd_decode.sv
// ----------------------------------------------------------------------------
// mahd_decode
// First stage: sync and reserved-code checks, table lookups and the scaled
// bitrate product that the frame length is derived from.
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_decode (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           in_valid,
  input  wire logic [7:0]     hdr_byte0,
  input  wire logic [7:0]     hdr_byte1,
  input  wire logic [7:0]     hdr_byte2,
  output logic                valid,
  output mahd_pkg::dec_t      dec
);

  mahd_pkg::dec_t dec_next;

  always_comb begin
    logic       nosync;
    logic [1:0] vcode;
    logic [1:0] lcode;
    logic [3:0] bidx;
    logic [1:0] ridx;
    logic [1:0] ver;
    logic [1:0] layer;
    logic [2:0] row;
    logic [2:0] kmul;
    logic [13:0] scaled;

    vcode = hdr_byte1[4:3];
    lcode = hdr_byte1[2:1];
    bidx  = hdr_byte2[7:4];
    ridx  = hdr_byte2[3:2];
    nosync = (hdr_byte0 != 8'hFF) || (hdr_byte1[7:5] != 3'b111) ||
             (bidx == 4'hF) || (hdr_byte2 == 8'h00);

    case (vcode)
      mahd_pkg::VCODE_MPEG1: ver = mahd_pkg::VER_MPEG1;
      mahd_pkg::VCODE_MPEG2: ver = mahd_pkg::VER_MPEG2;
      default:               ver = mahd_pkg::VER_MPEG25;
    endcase

    case (lcode)
      mahd_pkg::LCODE_LAYER3: layer = 2'd3;
      mahd_pkg::LCODE_LAYER2: layer = 2'd2;
      default:                layer = 2'd1;
    endcase

    if (ver == mahd_pkg::VER_MPEG1) begin
      row  = {1'b0, layer} - 3'd1;
      kmul = (layer == 2'd1) ? 3'd2 : 3'd6;
    end else begin
      row = {1'b0, layer} + 3'd2;
      case (layer)
        2'd1:    kmul = 3'd1;
        2'd2:    kmul = 3'd6;
        default: kmul = 3'd3;
      endcase
    end

    dec_next = '0;
    scaled   = '0;
    if (nosync) begin
      dec_next.err = mahd_pkg::ERR_SYNC;
    end else if (vcode == mahd_pkg::VCODE_RESERVED) begin
      dec_next.err = mahd_pkg::ERR_VERSION;
    end else if (lcode == mahd_pkg::LCODE_RESERVED) begin
      dec_next.err = mahd_pkg::ERR_LAYER;
    end else if (bidx == mahd_pkg::BIDX_FREE) begin
      dec_next.err = mahd_pkg::ERR_BITRATE;
    end else if (ridx == mahd_pkg::RIDX_RESERVED) begin
      dec_next.err = mahd_pkg::ERR_RATE;
    end else begin
      dec_next.ok    = 1'b1;
      dec_next.err   = mahd_pkg::ERR_NONE;
      dec_next.ver   = ver;
      dec_next.layer = layer;
      dec_next.ridx  = ridx;
      dec_next.rate  = mahd_pkg::rate_hz(ver, ridx);
      dec_next.kbps  = mahd_pkg::KBPS_TABLE[row][bidx];
      dec_next.pad   = hdr_byte2[1];
      scaled         = (14'(kmul) * 14'(mahd_pkg::KBPS_TABLE[row][bidx])) << ver;
      dec_next.prod  = scaled[11:0];
      dec_next.ftime = mahd_pkg::frame_time(layer, ver, ridx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dec <= dec_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mahd_scale.sv
// ----------------------------------------------------------------------------
// mahd_scale
// Second stage: reciprocal multiply for the 44.1 kHz family, where the
// frame length is floor(80 * prod / 147).
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_scale (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           in_valid,
  input  wire mahd_pkg::dec_t dec,
  output logic                valid,
  output mahd_pkg::mul_t      mul
);

  logic [18:0] x80;
  logic [38:0] product;
  mahd_pkg::mul_t mul_next;

  always_comb begin
    x80      = 19'({dec.prod, 6'b0}) + 19'({dec.prod, 4'b0});
    product  = 39'(x80) * 39'(mahd_pkg::RECIP_147);
    mul_next.dec = dec;
    mul_next.q44 = 12'(product >> mahd_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mul <= mul_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mahd_finish.sv
// ----------------------------------------------------------------------------
// mahd_finish
// Third stage: select the frame length for the rate family, add the padding
// byte and hold the result for the output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_finish (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           in_valid,
  input  wire mahd_pkg::mul_t mul,
  output logic                valid,
  output mahd_pkg::res_t      res
);

  mahd_pkg::res_t res_next;

  always_comb begin
    logic [11:0] base;
    logic [13:0] x3;

    x3 = 14'(mul.dec.prod) * 14'd3;
    case (mul.dec.ridx)
      mahd_pkg::RIDX_44K1: base = mul.q44;
      mahd_pkg::RIDX_48K:  base = mul.dec.prod >> 1;
      mahd_pkg::RIDX_32K:  base = x3[13:2];
      default:             base = 12'd0;
    endcase

    res_next.ok     = mul.dec.ok;
    res_next.err    = mul.dec.err;
    res_next.ver    = mul.dec.ver;
    res_next.layer  = mul.dec.layer;
    res_next.rate   = mul.dec.rate;
    res_next.kbps   = mul.dec.kbps;
    res_next.pad    = mul.dec.pad;
    res_next.fbytes = mul.dec.ok ? base + 12'(mul.dec.pad) : 12'd0;
    res_next.ftime  = mul.dec.ftime;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mpeg_audio_header_decode.sv
// The result reaches the output registers through the decode, scale and finish stages.
// Throughput: one header per cycle while out_stall is low; each stage holds one item and a stage
// refills whenever it is empty or its successor moves.
// A stalled output holds the last stage; bubbles in earlier stages still close.
// Reset: synchronous, active high; clears all stage valid bits.
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode
// Three-stage decoder for the first three bytes of an MPEG audio frame header.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_audio_header_decode (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  hdr_byte0,
  input  wire logic [7:0]  hdr_byte1,
  input  wire logic [7:0]  hdr_byte2,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             header_ok,
  output logic [2:0]       error_kind,
  output logic [1:0]       mpeg_version,
  output logic [1:0]       layer_number,
  output logic [15:0]      sample_rate_hz,
  output logic [8:0]       bitrate_kbps,
  output logic             padding_flag,
  output logic [11:0]      frame_bytes,
  output logic [17:0]      frame_time_us
);

  logic           v1;
  logic           v2;
  logic           v3;
  logic           adv1;
  logic           adv2;
  logic           adv3;
  mahd_pkg::dec_t dec;
  mahd_pkg::mul_t mul;
  mahd_pkg::res_t res;

  assign adv3     = !v3 || !out_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  mahd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv1),
    .in_valid  (in_valid),
    .hdr_byte0 (hdr_byte0),
    .hdr_byte1 (hdr_byte1),
    .hdr_byte2 (hdr_byte2),
    .valid     (v1),
    .dec       (dec)
  );

  mahd_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .advance  (adv2),
    .in_valid (v1),
    .dec      (dec),
    .valid    (v2),
    .mul      (mul)
  );

  mahd_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .advance  (adv3),
    .in_valid (v2),
    .mul      (mul),
    .valid    (v3),
    .res      (res)
  );

  assign out_valid      = v3;
  assign header_ok      = res.ok;
  assign error_kind     = res.err;
  assign mpeg_version   = res.ver;
  assign layer_number   = res.layer;
  assign sample_rate_hz = res.rate;
  assign bitrate_kbps   = res.kbps;
  assign padding_flag   = res.pad;
  assign frame_bytes    = res.fbytes;
  assign frame_time_us  = res.ftime;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && out_stall))
    else $error("input stalled with an empty stage");

  a_ok_no_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && header_ok) |-> (error_kind == mahd_pkg::ERR_NONE &&
                                  sample_rate_hz != 16'd0 && bitrate_kbps != 9'd0))
    else $error("decoded header without rate or bitrate");

  a_error_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !header_ok) |-> (error_kind != mahd_pkg::ERR_NONE &&
                                   frame_bytes == 12'd0 && frame_time_us == 18'd0))
    else $error("error result carries decoded fields");

  a_entry_reaches_stage1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted header lost at first stage");

endmodule

`default_nettype wire
